// ===== src/rdsc_pkg.sv =====
package rdsc_pkg;

   localparam int CHAR_W  = 7;
   localparam int RADIX_W = 6;
   localparam int FDIG_W  = 5;
   localparam int DIGIT_W = 6;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [FDIG_W-1:0]  FDIG_RESET  = 5'd4;

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
   localparam logic [CHAR_W-1:0] CHAR_COMMA = 7'd44;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT = 7'd48;
   localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'd55;

   localparam logic CSR_RADIX = 1'b0;
   localparam logic CSR_FDIG  = 1'b1;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last;
   } rsp_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      if (d <= 6'd9) return CHAR_DIGIT + {1'b0, d};
      else return CHAR_ALPHA + {1'b0, d};
   endfunction

endpackage

// ===== src/radix_digit_string_converter.sv =====
// Each integer digit is found by bit-serial division; then characters are emitted
// one per cycle (up to MAX_CHARS) through registered outputs. While one item is
// converted, one more can wait in the front queue. Results cannot be stalled.
// Synchronous reset sets radix 10, four fraction digits, empty queue.
module radix_digit_string_converter #(
   parameter int INT_BITS  = 31,
   parameter int FRAC_BITS = 32,
   parameter int MAX_CHARS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_negative,
   input  logic [INT_BITS-1:0]           req_int_part,
   input  logic [FRAC_BITS-1:0]          req_frac_part,
   output logic                          rsp_valid,
   output rdsc_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [31:0]                   csr_wdata
);
   import rdsc_pkg::*;

   logic [RADIX_W-1:0]   radix_ff;
   logic [FDIG_W-1:0]    fdig_ff;
   logic                 q_valid, q_pop, q_neg;
   logic [INT_BITS-1:0]  q_int;
   logic [FRAC_BITS-1:0] q_frac;
   logic [RADIX_W-1:0]   q_radix;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
         fdig_ff  <= FDIG_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_RADIX: radix_ff <= csr_wdata[RADIX_W-1:0];
            CSR_FDIG:  fdig_ff  <= csr_wdata[FDIG_W-1:0];
            default: ;
         endcase
      end
   end

   rdsc_front #(.INT_BITS(INT_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock, .reset, .start, .busy,
      .neg(req_negative), .int_in(req_int_part), .frac_in(req_frac_part),
      .radix_raw(radix_ff), .q_valid, .q_pop, .q_neg, .q_int, .q_frac, .q_radix
   );

   rdsc_back #(.INT_BITS(INT_BITS), .FRAC_BITS(FRAC_BITS), .MAX_CHARS(MAX_CHARS)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_neg, .q_int, .q_frac, .q_radix,
      .fdig(fdig_ff), .rsp_valid, .rsp(rsp_data)
   );
endmodule

// ===== src/rdsc_front.sv =====
// Front: latch one item and the saturated radix, push into a one-entry queue.
module rdsc_front #(
   parameter int INT_BITS  = 31,
   parameter int FRAC_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         neg,
   input  logic [INT_BITS-1:0]          int_in,
   input  logic [FRAC_BITS-1:0]         frac_in,
   input  logic [rdsc_pkg::RADIX_W-1:0] radix_raw,
   output logic                         q_valid,
   input  logic                         q_pop,
   output logic                         q_neg,
   output logic [INT_BITS-1:0]          q_int,
   output logic [FRAC_BITS-1:0]         q_frac,
   output logic [rdsc_pkg::RADIX_W-1:0] q_radix
);
   import rdsc_pkg::*;

   logic                 valid_ff, valid_in;
   logic                 neg_ff;
   logic [INT_BITS-1:0]  int_ff;
   logic [FRAC_BITS-1:0] frac_ff;
   logic [RADIX_W-1:0]   radix_ff, radix_in;

   assign busy = valid_ff;
   assign valid_in = (valid_ff && !q_pop) || (start && !valid_ff);

   always_comb begin
      if (radix_raw < RADIX_MIN) radix_in = RADIX_MIN;
      else if (radix_raw > RADIX_MAX) radix_in = RADIX_MAX;
      else radix_in = radix_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (start && !valid_ff) begin
         neg_ff   <= neg;
         int_ff   <= int_in;
         frac_ff  <= frac_in;
         radix_ff <= radix_in;
      end
   end

   assign q_valid = valid_ff;
   assign q_neg   = neg_ff;
   assign q_int   = int_ff;
   assign q_frac  = frac_ff;
   assign q_radix = radix_ff;

   a_pop_valid: assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("pop from empty queue");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !q_pop |=> valid_ff && $stable(int_ff))
      else $error("queue entry lost");
   a_radix: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> radix_ff >= RADIX_MIN && radix_ff <= RADIX_MAX)
      else $error("radix out of range");
endmodule

// ===== src/rdsc_back.sv =====
// Back: restoring division per integer digit (one quotient bit a cycle),
// digits stored in flops, then emit sign (if negative), digits, comma, fraction digits.
module rdsc_back #(
   parameter int INT_BITS  = 31,
   parameter int FRAC_BITS = 32,
   parameter int MAX_CHARS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   output logic                         q_pop,
   input  logic                         q_neg,
   input  logic [INT_BITS-1:0]          q_int,
   input  logic [FRAC_BITS-1:0]         q_frac,
   input  logic [rdsc_pkg::RADIX_W-1:0] q_radix,
   input  logic [rdsc_pkg::FDIG_W-1:0]  fdig,
   output logic                         rsp_valid,
   output rdsc_pkg::rsp_type            rsp
);
   import rdsc_pkg::*;

   localparam int NDIG   = INT_BITS + 1;
   localparam int AW     = $clog2(NDIG);
   localparam int DCW    = $clog2(NDIG + 1);
   localparam int BCW    = $clog2(INT_BITS + 1);
   localparam int ECW    = $clog2(MAX_CHARS + 1);
   localparam int PW     = FRAC_BITS + RADIX_W;

   localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_SIGN = 3'd2,
                          S_INT = 3'd3, S_COMMA = 3'd4, S_FRAC = 3'd5;

   logic [2:0]           st_ff, st_in;
   logic [INT_BITS-1:0]  q_ff, q_in;
   logic [RADIX_W-1:0]   rem_ff, rem_in;
   logic [BCW-1:0]       bit_ff, bit_in;
   logic [DCW-1:0]       dcnt_ff, dcnt_in;
   logic [ECW-1:0]       ecnt_ff, ecnt_in;
   logic [FDIG_W-1:0]    fcnt_ff, fcnt_in;
   logic [FRAC_BITS-1:0] frac_ff, frac_in;
   logic [RADIX_W-1:0]   radix_ff;
   logic                 neg_ff;
   logic [DIGIT_W-1:0]   store_ff [NDIG];
   logic [AW-1:0]        rd_idx;
   logic                 wr_en;
   logic                 emit;
   logic [CHAR_W-1:0]    ch;
   logic                 fin;
   logic [RADIX_W:0]     trial;
   logic [PW-1:0]        prod;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   assign trial = {rem_ff, q_ff[INT_BITS-1]};
   assign prod  = frac_ff * {{(PW-RADIX_W){1'b0}}, radix_ff};
   assign rd_idx = AW'(dcnt_ff - 1'b1);

   function automatic logic [DIGIT_W-1:0] rem_in_digit();
      if (trial >= {1'b0, radix_ff}) return DIGIT_W'(trial - {1'b0, radix_ff});
      else return trial[DIGIT_W-1:0];
   endfunction

   always_comb begin
      st_in = st_ff; q_in = q_ff; rem_in = rem_ff; bit_in = bit_ff;
      dcnt_in = dcnt_ff; ecnt_in = ecnt_ff; fcnt_in = fcnt_ff; frac_in = frac_ff;
      wr_en = 1'b0; emit = 1'b0; ch = CHAR_COMMA; fin = 1'b0; q_pop = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1; q_in = q_int; frac_in = q_frac; rem_in = '0;
               bit_in = '0; dcnt_in = '0; ecnt_in = '0; fcnt_in = '0;
               st_in = S_DIV;
            end
         end
         S_DIV: begin
            // shift one dividend bit into the remainder, subtract if it fits
            q_in = q_ff << 1;
            if (trial >= {1'b0, radix_ff}) begin
               rem_in = RADIX_W'(trial - {1'b0, radix_ff});
               q_in[0] = 1'b1;
            end else begin
               rem_in = trial[RADIX_W-1:0];
            end
            bit_in = bit_ff + 1'b1;
            if (bit_ff == BCW'(INT_BITS - 1)) begin
               wr_en = 1'b1;
               dcnt_in = dcnt_ff + 1'b1;
               bit_in = '0;
               rem_in = '0;
               if (q_in == '0 || dcnt_in == DCW'(NDIG))
                  st_in = neg_ff ? S_SIGN : S_INT;
            end
         end
         S_SIGN: begin
            emit = 1'b1; ch = CHAR_MINUS; st_in = S_INT;
         end
         S_INT: begin
            emit = 1'b1;
            ch = digit_char(store_ff[rd_idx]);
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == DCW'(1)) st_in = S_COMMA;
         end
         S_COMMA: begin
            emit = 1'b1; ch = CHAR_COMMA;
            if (fdig == '0) fin = 1'b1;
            st_in = S_FRAC;
         end
         S_FRAC: begin
            emit = 1'b1;
            ch = digit_char(prod[PW-1:FRAC_BITS]);
            frac_in = prod[FRAC_BITS-1:0];
            fcnt_in = fcnt_ff + 1'b1;
            if (fcnt_in == fdig) fin = 1'b1;
         end
         default: st_in = S_IDLE;
      endcase
      if (emit) begin
         ecnt_in = ecnt_ff + 1'b1;
         if (ecnt_in == ECW'(MAX_CHARS)) fin = 1'b1;
      end
      if (fin) st_in = S_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         q_ff <= '0; rem_ff <= '0; bit_ff <= '0; dcnt_ff <= '0;
         ecnt_ff <= '0; fcnt_ff <= '0; frac_ff <= '0;
      end else begin
         st_ff <= st_in;
         rsp_valid_ff <= emit;
         q_ff <= q_in; rem_ff <= rem_in; bit_ff <= bit_in; dcnt_ff <= dcnt_in;
         ecnt_ff <= ecnt_in; fcnt_ff <= fcnt_in; frac_ff <= frac_in;
      end
      if (q_pop) begin
         radix_ff <= q_radix;
         neg_ff <= q_neg;
      end
      if (wr_en) store_ff[dcnt_ff[AW-1:0]] <= rem_in_digit();
      rsp_ff.char_code <= ch;
      rsp_ff.last <= fin;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   a_fin_emit: assert property (@(posedge clock) disable iff (reset) fin |-> emit)
      else $error("last without character");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> st_ff == S_IDLE)
      else $error("pop while working");
   a_cap: assert property (@(posedge clock) disable iff (reset)
      ecnt_ff <= ECW'(MAX_CHARS))
      else $error("too many characters");
endmodule
